// ===== design/tcpq_pkg.sv =====
`default_nettype none

package tcpq_pkg;

   localparam int CLASS_DEPTH_DEF = 16;
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int NUM_CLASSES     = 3;

   localparam int CLASS_W    = 2;
   localparam int ITEM_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 5;
   localparam int TOTAL_W    = 6;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 96;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

`default_nettype wire

// ===== design/three_class_priority_queue.sv =====
// three-class strict priority queue, one ring per class in a single ring memory
// response: push, failed pop, or pop that empties the queue -> result registered straight from the request
//           pop that leaves items -> result after the ST_READ state (ring read of the new head)
// rate: one request per cycle for pushes while the response channel is not stalled; such pops hold off
//       new requests while in ST_READ, since the ring memory read data is registered
// reset: synchronous, clears fill counts, ring pointers and handshake state; ring memory keeps
//        its contents (entries are only read once written), no clearing pass
`default_nettype none

module three_class_priority_queue #(
   parameter int CLASS_DEPTH = tcpq_pkg::CLASS_DEPTH_DEF,
   parameter int VALUE_WIDTH = tcpq_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [tcpq_pkg::ITEM_W-1:0]     req_tdata,  // [31:0] item_value
   input  wire logic [tcpq_pkg::REQ_USER_W-1:0] req_tuser,  // [0] opcode, [2:1] priority_class
   // response channel
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [31:0] popped_value, [33:32] popped_class, [34] head_valid, [66:35] head_value,
   // [68:67] head_class, [73:69] count_high, [78:74] count_medium, [83:79] count_low,
   // [89:84] total_count, [95:90] zero
   output logic [tcpq_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [tcpq_pkg::STATUS_W-1:0]        rsp_tuser   // [1:0] status
);

   localparam int NCLS      = tcpq_pkg::NUM_CLASSES;
   localparam int CLASS_W   = tcpq_pkg::CLASS_W;
   localparam int ITEM_W    = tcpq_pkg::ITEM_W;
   localparam int PTR_W     = $clog2(CLASS_DEPTH);
   localparam int CNT_W     = $clog2(CLASS_DEPTH + 1);
   localparam int MEM_DEPTH = NCLS * CLASS_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int SUM_W     = $clog2(MEM_DEPTH + 1);
   localparam int WIDE_W    = (VALUE_WIDTH > ITEM_W) ? VALUE_WIDTH : ITEM_W;

   // ring pointer step with wrap at the class depth
   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(CLASS_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   // item as kept in the ring: sign extended or cut to the stored width
   function automatic logic [VALUE_WIDTH-1:0] to_stored(input logic signed [ITEM_W-1:0] v);
      logic signed [WIDE_W-1:0] w;
      w = WIDE_W'(v);
      return w[VALUE_WIDTH-1:0];
   endfunction

   // stored value sign extended from the stored width, reported in the low bits
   function automatic logic [ITEM_W-1:0] to_report(input logic [VALUE_WIDTH-1:0] v);
      logic signed [WIDE_W-1:0] w;
      w = WIDE_W'(signed'(v));
      return w[ITEM_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] ring_addr(input logic [CLASS_W-1:0] c,
                                                   input logic [PTR_W-1:0]   p);
      return ADDR_W'(c) * ADDR_W'(CLASS_DEPTH) + ADDR_W'(p);
   endfunction

   // control state
   tcpq_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]    fill_ff [NCLS];
   logic [CNT_W-1:0]    fill_in [NCLS];
   logic [PTR_W-1:0]    rp_ff   [NCLS];
   logic [PTR_W-1:0]    rp_in   [NCLS];
   logic [PTR_W-1:0]    wp_ff   [NCLS];
   logic [PTR_W-1:0]    wp_in   [NCLS];

   // cached copy of the current head entry
   logic [VALUE_WIDTH-1:0] head_val_ff, head_val_in;

   // ring memory, read data registered
   logic [VALUE_WIDTH-1:0] ring_mem [MEM_DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;
   logic                   mem_we, mem_re;
   logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
   logic [VALUE_WIDTH-1:0] mem_wdata;

   // response register fields
   tcpq_pkg::status_type      out_status_ff, out_status_in;
   logic [ITEM_W-1:0]         out_pval_ff, out_pval_in;
   logic [CLASS_W-1:0]        out_pcls_ff, out_pcls_in;
   logic                      out_hvalid_ff, out_hvalid_in;
   logic [ITEM_W-1:0]         out_hval_ff, out_hval_in;
   logic [CLASS_W-1:0]        out_hcls_ff, out_hcls_in;
   logic [tcpq_pkg::COUNT_W-1:0] out_cnt_ff [NCLS];
   logic [tcpq_pkg::COUNT_W-1:0] out_cnt_in [NCLS];
   logic [tcpq_pkg::TOTAL_W-1:0] out_total_ff, out_total_in;
   logic                      out_load, out_head_load;

   // request decode
   logic                   req_fire;
   logic                   is_pop;
   logic [CLASS_W-1:0]     req_class;
   logic [NCLS-1:0]        cls_oh;
   logic [NCLS-1:0]        full_vec;
   logic [NCLS-1:0]        nonempty, nonempty_in;
   logic [NCLS-1:0]        head_oh, head_oh_in;
   logic [CLASS_W-1:0]     head_cls, head_cls_in;
   logic                   any_ne, any_ne_in;
   logic                   cls_ok, push_ok, pop_ok, push_new_head;
   logic [NCLS-1:0]        push_hit, pop_hit;
   logic [PTR_W-1:0]       wpos, rpos_in;
   logic [SUM_W-1:0]       total_in;

   // a request is taken only when idle and the response register is free this cycle
   assign req_tready = (state_ff == tcpq_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign is_pop     = (req_tuser[0] == tcpq_pkg::OP_POP);
   assign req_class  = req_tuser[2:1];
   assign cls_ok     = (req_class < CLASS_W'(NCLS));

   // class status and head selection, highest class first
   always_comb begin
      logic seen, seen_in;
      seen        = 1'b0;
      seen_in     = 1'b0;
      head_cls    = '0;
      head_cls_in = '0;
      wpos        = '0;
      rpos_in     = '0;
      total_in    = '0;
      for (int c = 0; c < NCLS; c++) begin
         cls_oh[c]   = (req_class == CLASS_W'(c));
         full_vec[c] = (fill_ff[c] >= CNT_W'(CLASS_DEPTH));
         nonempty[c] = (fill_ff[c] != '0);
         head_oh[c]  = nonempty[c] && !seen;
         seen        = seen || nonempty[c];
         if (head_oh[c]) begin
            head_cls = CLASS_W'(c);
         end
      end
      any_ne  = seen;
      push_ok = cls_ok && !(|(cls_oh & full_vec));
      pop_ok  = any_ne;

      // next pointers and fills
      for (int c = 0; c < NCLS; c++) begin
         push_hit[c] = req_fire && !is_pop && push_ok && cls_oh[c];
         pop_hit[c]  = req_fire && is_pop && pop_ok && head_oh[c];
         fill_in[c]  = fill_ff[c] + CNT_W'(push_hit[c]) - CNT_W'(pop_hit[c]);
         wp_in[c]    = push_hit[c] ? advance(wp_ff[c]) : wp_ff[c];
         rp_in[c]    = pop_hit[c]  ? advance(rp_ff[c]) : rp_ff[c];
         if (cls_oh[c]) begin
            wpos = wp_ff[c];
         end
         total_in = total_in + SUM_W'(fill_in[c]);
      end

      // head after this request
      for (int c = 0; c < NCLS; c++) begin
         nonempty_in[c] = (fill_in[c] != '0);
         head_oh_in[c]  = nonempty_in[c] && !seen_in;
         seen_in        = seen_in || nonempty_in[c];
         if (head_oh_in[c]) begin
            head_cls_in = CLASS_W'(c);
            rpos_in     = rp_in[c];
         end
      end
      any_ne_in     = seen_in;
      push_new_head = push_ok && (!any_ne || (req_class < head_cls));
   end

   // ring memory ports
   assign mem_we    = |push_hit;
   assign mem_waddr = ring_addr(req_class, wpos);
   assign mem_wdata = to_stored(signed'(req_tdata));
   assign mem_raddr = ring_addr(head_cls_in, rpos_in);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= ring_mem[mem_raddr];
      end
   end

   // sequencer: a pop that leaves items waits in ST_READ for the new head
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      mem_re        = 1'b0;
      out_load      = 1'b0;
      out_head_load = 1'b0;
      head_val_in   = head_val_ff;
      unique case (state_ff)
         tcpq_pkg::ST_IDLE: begin
            if (req_fire) begin
               out_load = 1'b1;
               if (is_pop && pop_ok && any_ne_in) begin
                  mem_re   = 1'b1;
                  state_in = tcpq_pkg::ST_READ;
               end else begin
                  rsp_valid_in = 1'b1;
                  if (!is_pop && push_new_head) begin
                     head_val_in = mem_wdata;
                  end
               end
            end
         end
         tcpq_pkg::ST_READ: begin
            out_head_load = 1'b1;
            head_val_in   = rd_data_ff;
            rsp_valid_in  = 1'b1;
            state_in      = tcpq_pkg::ST_IDLE;
         end
         default: begin
            state_in = tcpq_pkg::ST_IDLE;
         end
      endcase
   end

   // response field values
   always_comb begin
      out_status_in = tcpq_pkg::STATUS_DONE;
      out_pval_in   = '0;
      out_pcls_in   = '0;
      if (is_pop) begin
         if (pop_ok) begin
            out_pval_in = to_report(head_val_ff);
            out_pcls_in = head_cls;
         end else begin
            out_status_in = tcpq_pkg::STATUS_EMPTY;
         end
      end else if (!push_ok) begin
         out_status_in = tcpq_pkg::STATUS_FULL;
      end
      out_hvalid_in = any_ne_in;
      out_hcls_in   = any_ne_in ? head_cls_in : '0;
      if (!any_ne_in) begin
         out_hval_in = '0;
      end else if (!is_pop && push_new_head) begin
         out_hval_in = to_report(mem_wdata);
      end else begin
         out_hval_in = to_report(head_val_ff);
      end
      for (int c = 0; c < NCLS; c++) begin
         out_cnt_in[c] = tcpq_pkg::COUNT_W'(fill_in[c]);
      end
      out_total_in = tcpq_pkg::TOTAL_W'(total_in);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcpq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NCLS; c++) begin
            fill_ff[c] <= '0;
            rp_ff[c]   <= '0;
            wp_ff[c]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int c = 0; c < NCLS; c++) begin
            fill_ff[c] <= fill_in[c];
            rp_ff[c]   <= rp_in[c];
            wp_ff[c]   <= wp_in[c];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      head_val_ff <= head_val_in;
      if (out_load) begin
         out_status_ff <= out_status_in;
         out_pval_ff   <= out_pval_in;
         out_pcls_ff   <= out_pcls_in;
         out_hvalid_ff <= out_hvalid_in;
         out_hval_ff   <= out_hval_in;
         out_hcls_ff   <= out_hcls_in;
         out_total_ff  <= out_total_in;
         for (int c = 0; c < NCLS; c++) begin
            out_cnt_ff[c] <= out_cnt_in[c];
         end
      end else if (out_head_load) begin
         // new head arrives from the ring read
         out_hval_ff <= to_report(rd_data_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {6'b0, out_total_ff, out_cnt_ff[2], out_cnt_ff[1], out_cnt_ff[0],
                        out_hcls_ff, out_hval_ff, out_hvalid_ff, out_pcls_ff, out_pval_ff};

   // checks
   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcpq_pkg::ST_READ) |=> (state_ff == tcpq_pkg::ST_IDLE))
      else $error("head read held longer than one cycle");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (fill_ff[0] <= CNT_W'(CLASS_DEPTH)) && (fill_ff[1] <= CNT_W'(CLASS_DEPTH)) &&
      (fill_ff[2] <= CNT_W'(CLASS_DEPTH)))
      else $error("class fill above ring depth");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_pop && !any_ne) |=>
      (rsp_valid_ff && (out_status_ff == tcpq_pkg::STATUS_EMPTY)))
      else $error("pop on empty queue not flagged");

   a_reject_keeps: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !is_pop && !push_ok) |=>
      ($stable(fill_ff[0]) && $stable(fill_ff[1]) && $stable(fill_ff[2]) &&
       (out_status_ff == tcpq_pkg::STATUS_FULL)))
      else $error("rejected push changed the queue");

endmodule

`default_nettype wire
